// ----- design/fcis_pkg.sv -----
package fcis_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned VALUE_W  = 32;
  // one slot word: valid flag on top of the value
  localparam int unsigned SLOT_W   = VALUE_W + 1;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_e;

endpackage

// ----- design/fcis_ram.sv -----
module fcis_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fixed_capacity_integer_set_top.sv -----
// Set of up to 128 signed 32-bit values, held in a single-port slot RAM whose
// words carry a valid flag above the value.
// Input stream (s_axis): one request per transaction, tdata carries the
// request kind and the value. Output stream (m_axis): one result per request,
// tdata carries the success flag and the status code.
// Insert, remove and query each sweep all slots, one read a cycle. The result
// register is loaded after the reads, the compare of the last slot, and then
// in the write-back step, which stores an insert or remove in its slot.
// Clear writes every slot invalid, one write a cycle, and then presents its
// result through the same done step.
// The RAM port is the limit: one read or one write per cycle. With a ready
// receiver a new request can be taken in the same cycle as the result is
// presented.
// One request is in progress at a time; s_axis_tready is high only when
// the block is idle and the result register is empty or being drained.
// When the receiver stalls, the result is held in its register and a
// finished request waits before writing back.
// After reset the same clearing pass runs over all slots, so s_axis_tready
// stays low until that pass has finished.
module fixed_capacity_integer_set_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] req_type, [33:2] value, [39:34] zero
  input  logic [fcis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] ok, [2:1] status, [7:3] zero
  output logic [fcis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import fcis_pkg::*;

  typedef enum logic [1:0] {
    S_WIPE,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

  state_e               state_q;
  req_e                 req_q;
  logic [VALUE_W-1:0]   value_q;
  logic [ADDR_W-1:0]    rd_addr_q;
  logic                 issue_done_q;
  logic                 cmp_pend_q;
  logic [ADDR_W-1:0]    cmp_addr_q;
  logic                 hit_found_q;
  logic [ADDR_W-1:0]    hit_idx_q;
  logic                 free_found_q;
  logic [ADDR_W-1:0]    free_idx_q;
  logic                 out_valid_q;
  logic                 ok_q;
  status_e              status_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 ram_en;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [SLOT_W-1:0]    ram_wdata;
  logic [SLOT_W-1:0]    ram_rdata;
  logic                 slot_valid;
  logic                 slot_match;
  logic                 ins_ok;
  logic                 rem_ok;
  req_e                 in_req;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_e'(s_axis_tdata[1:0]);

  assign slot_valid = ram_rdata[VALUE_W];
  assign slot_match = slot_valid && (ram_rdata[VALUE_W-1:0] == value_q);
  assign ins_ok     = (req_q == REQ_INSERT) && !hit_found_q && free_found_q;
  assign rem_ok     = (req_q == REQ_REMOVE) && hit_found_q;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr_q;
    ram_wdata = '0;
    if (state_q == S_WIPE) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
    end else if (state_q == S_SCAN && !issue_done_q) begin
      ram_en = 1'b1;
    end else if (state_q == S_DONE && out_free && ins_ok) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = free_idx_q;
      ram_wdata = {1'b1, value_q};
    end else if (state_q == S_DONE && out_free && rem_ok) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = hit_idx_q;
      ram_wdata = {1'b0, value_q};
    end
  end

  fcis_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_WIPE;
      req_q        <= REQ_INSERT;
      value_q      <= '0;
      rd_addr_q    <= '0;
      issue_done_q <= 1'b0;
      cmp_pend_q   <= 1'b0;
      cmp_addr_q   <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      ok_q         <= 1'b0;
      status_q     <= ST_SUCCESS;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      cmp_pend_q <= (state_q == S_SCAN) && !issue_done_q;
      cmp_addr_q <= rd_addr_q;

      case (state_q)
        S_WIPE: begin
          // invalidate one slot a cycle; only a clear request reports back
          rd_addr_q <= rd_addr_q + 1'b1;
          if (rd_addr_q == LAST_ADDR) begin
            state_q <= (req_q == REQ_CLEAR) ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            req_q        <= in_req;
            value_q      <= s_axis_tdata[VALUE_W+1:2];
            rd_addr_q    <= '0;
            issue_done_q <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            if (in_req == REQ_CLEAR) begin
              state_q <= S_WIPE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (!issue_done_q) begin
            rd_addr_q <= rd_addr_q + 1'b1;
            if (rd_addr_q == LAST_ADDR) begin
              issue_done_q <= 1'b1;
            end
          end
          if (cmp_pend_q) begin
            // keep the lowest matching slot and the lowest free slot
            if (slot_match && !hit_found_q) begin
              hit_found_q <= 1'b1;
              hit_idx_q   <= cmp_addr_q;
            end
            if (!slot_valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= cmp_addr_q;
            end
            if (cmp_addr_q == LAST_ADDR) begin
              state_q <= S_DONE;
            end
          end
        end

        S_DONE: begin
          // hold the write-back until the result register can take the result
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            case (req_q)
              REQ_INSERT: begin
                if (hit_found_q) begin
                  ok_q     <= 1'b0;
                  status_q <= ST_PRESENT;
                end else if (!free_found_q) begin
                  ok_q     <= 1'b0;
                  status_q <= ST_FULL;
                end else begin
                  ok_q     <= 1'b1;
                  status_q <= ST_SUCCESS;
                end
              end
              REQ_REMOVE: begin
                if (hit_found_q) begin
                  ok_q     <= 1'b1;
                  status_q <= ST_SUCCESS;
                end else begin
                  ok_q     <= 1'b0;
                  status_q <= ST_ABSENT;
                end
              end
              REQ_QUERY: begin
                ok_q     <= hit_found_q;
                status_q <= hit_found_q ? ST_SUCCESS : ST_ABSENT;
              end
              default: begin
                ok_q     <= 1'b1;
                status_q <= ST_SUCCESS;
              end
            endcase
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, status_q, ok_q};

  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req == REQ_CLEAR) |=> (state_q == S_WIPE))
    else $error("clear did not start a sweep");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WIPE || state_q == S_DONE))
    else $error("slot write outside wipe or write-back");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ok_q == (status_q == ST_SUCCESS)))
    else $error("ok flag disagrees with status");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_pend_q |-> (state_q == S_SCAN))
    else $error("compare pending outside sweep");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule
